// File: design/fcc_pkg.sv
`timescale 1ns / 1ps

package fcc_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 4096;
  localparam int ADDR_W        = $clog2(TABLE_ENTRIES);
  localparam int LEN_W         = ADDR_W + 1;
  localparam int VAL_W         = 16;

  // link codes and fixed clusters
  localparam logic [VAL_W-1:0]  END_OF_CHAIN       = 16'hFFFF;
  localparam logic [VAL_W-1:0]  FREE_LINK          = '0;
  localparam logic [ADDR_W-1:0] ROOT_CLUSTER       = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] NO_CLUSTER         = '0;
  localparam logic [LEN_W-1:0]  FIRST_DATA_CLUSTER = LEN_W'(2);

  // request modes
  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_WRITE  = 2'd2,
    MODE_READ   = 2'd3
  } mode_t;

  // datapath operations, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_CAPTURE,
    DP_SCAN_RD,
    DP_SCAN_EV,
    DP_SCAN_WRAP,
    DP_SCAN_FAIL,
    DP_LINK,
    DP_MARK,
    DP_WALK_RD,
    DP_WALK_EV,
    DP_END_PREV,
    DP_PUT,
    DP_GET_RD,
    DP_GET_EV,
    DP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic  clear_last;
    mode_t mode;
    logic  scan_in_range;
    logic  scan_wrapped;
    logic  scan_hit;
    logic  walk_live;
    logic  out_busy;
  } dp_stat_t;

endpackage

// File: design/fcc_if.sv
`timescale 1ns / 1ps

// request word channel
interface fcc_req_if import fcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [ADDR_W-1:0] cluster;
  logic [ADDR_W-1:0] prev_cluster;
  logic [VAL_W-1:0]  entry_value;

  modport source (output valid, mode, cluster, prev_cluster, entry_value, input ready);
  modport sink   (input valid, mode, cluster, prev_cluster, entry_value, output ready);
endinterface

// result word channel
interface fcc_rsp_if import fcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] result_value;
  logic             status;

  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

// configuration write channel
interface fcc_cfg_if import fcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] entries_in_use;

  modport source (output valid, entries_in_use, input ready);
  modport sink   (input valid, entries_in_use, output ready);
endinterface

// File: design/fat_cluster_chain_manager.sv
`timescale 1ns / 1ps

// Cluster link table (4096 x 16 bits) with a next-fit allocator. After reset
// the block clears the table one entry at a time (root cluster 1 becomes
// end-of-chain) and takes no request words until that is done; configuration
// writes are taken throughout. One request is handled at a time, driven by a
// controller through a table with one write port and one registered read port.
// Allocate reads and tests one entry at a time: the scan runs from the search
// pointer up to the in-use length, then from cluster 2 up to the pointer.
// Remove walks the chain one link at a time, freeing each entry, and then marks
// the previous cluster as end-of-chain. The next request word is taken while
// the previous result word still waits on the output.

module fat_cluster_chain_manager import fcc_pkg::*; (
  input logic   clk,
  input logic   rst_n,
  fcc_req_if.sink   in_req,
  fcc_rsp_if.source out_rsp,
  fcc_cfg_if.sink   cfg_wr
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration is always taken
  assign cfg_wr.ready = 1'b1;

  fcc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fcc_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_mode            (in_req.mode),
    .in_cluster         (in_req.cluster),
    .in_prev_cluster    (in_req.prev_cluster),
    .in_entry_value     (in_req.entry_value),
    .cfg_valid          (cfg_wr.valid),
    .cfg_entries_in_use (cfg_wr.entries_in_use),
    .out_valid          (out_rsp.valid),
    .out_ready          (out_rsp.ready),
    .out_result_value   (out_rsp.result_value),
    .out_status         (out_rsp.status)
  );

endmodule

// File: design/fcc_ram.sv
`timescale 1ns / 1ps

module fcc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/fcc_ctrl.sv
`timescale 1ns / 1ps

module fcc_ctrl import fcc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISP,
    ST_SCAN,
    ST_SCAN_EV,
    ST_LINK,
    ST_MARK,
    ST_WALK,
    ST_WALK_EV,
    ST_END_PREV,
    ST_PUT,
    ST_GET,
    ST_GET_EV,
    ST_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   in_ready_r, in_ready_nxt;

  // next state and datapath command
  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.op = DP_CLEAR;
        if (stat.clear_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.op    = DP_CAPTURE;
          state_nxt = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (stat.mode)
          MODE_ALLOC:  state_nxt = ST_SCAN;
          MODE_REMOVE: state_nxt = ST_WALK;
          MODE_WRITE:  state_nxt = ST_PUT;
          MODE_READ:   state_nxt = ST_GET;
          default:     state_nxt = ST_FIN;
        endcase
      end
      // free-entry search: check bound, then read and test one entry
      ST_SCAN: begin
        if (stat.scan_in_range) begin
          cmd.op    = DP_SCAN_RD;
          state_nxt = ST_SCAN_EV;
        end else if (!stat.scan_wrapped) begin
          cmd.op = DP_SCAN_WRAP;
        end else begin
          cmd.op    = DP_SCAN_FAIL;
          state_nxt = ST_FIN;
        end
      end
      ST_SCAN_EV: begin
        cmd.op    = DP_SCAN_EV;
        state_nxt = stat.scan_hit ? ST_LINK : ST_SCAN;
      end
      ST_LINK: begin
        cmd.op    = DP_LINK;
        state_nxt = ST_MARK;
      end
      ST_MARK: begin
        cmd.op    = DP_MARK;
        state_nxt = ST_FIN;
      end
      // chain walk: read link, free entry, follow
      ST_WALK: begin
        if (stat.walk_live) begin
          cmd.op    = DP_WALK_RD;
          state_nxt = ST_WALK_EV;
        end else begin
          state_nxt = ST_END_PREV;
        end
      end
      ST_WALK_EV: begin
        cmd.op    = DP_WALK_EV;
        state_nxt = ST_WALK;
      end
      ST_END_PREV: begin
        cmd.op    = DP_END_PREV;
        state_nxt = ST_FIN;
      end
      ST_PUT: begin
        cmd.op    = DP_PUT;
        state_nxt = ST_FIN;
      end
      ST_GET: begin
        cmd.op    = DP_GET_RD;
        state_nxt = ST_GET_EV;
      end
      ST_GET_EV: begin
        cmd.op    = DP_GET_EV;
        state_nxt = ST_FIN;
      end
      // hand the result to the output register once it is free
      ST_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = DP_FINISH;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  assign in_ready_nxt = (state_nxt == ST_IDLE);

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= in_ready_nxt;
    end
  end

  assign in_ready = in_ready_r;

endmodule

// File: design/fcc_dp.sv
`timescale 1ns / 1ps

module fcc_dp import fcc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [1:0]        in_mode,
  input  logic [ADDR_W-1:0] in_cluster,
  input  logic [ADDR_W-1:0] in_prev_cluster,
  input  logic [VAL_W-1:0]  in_entry_value,
  input  logic              cfg_valid,
  input  logic [LEN_W-1:0]  cfg_entries_in_use,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [VAL_W-1:0]  out_result_value,
  output logic              out_status
);

  // control registers
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [LEN_W-1:0]  cfg_len_r, cfg_len_nxt;
  logic [ADDR_W-1:0] search_start_r, search_start_nxt;
  logic              out_valid_r, out_valid_nxt;
  // request and work registers
  mode_t             mode_r, mode_nxt;
  logic [ADDR_W-1:0] clst_r, clst_nxt;
  logic [ADDR_W-1:0] prev_r, prev_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic [VAL_W-1:0]  cur_r, cur_nxt;
  logic [VAL_W-1:0]  res_r, res_nxt;
  logic              fail_r, fail_nxt;
  logic [VAL_W-1:0]  out_res_r, out_res_nxt;
  logic              out_stat_r, out_stat_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [VAL_W-1:0]  ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;
  logic [LEN_W-1:0]  len_cap;
  logic [LEN_W-1:0]  scan_limit;

  fcc_ram #(
    .WIDTH (VAL_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // search bounds: first pass to the in-use length, wrapped pass to the pointer
  assign len_cap    = (cfg_len_r > LEN_W'(TABLE_ENTRIES)) ? LEN_W'(TABLE_ENTRIES) : cfg_len_r;
  assign scan_limit = wrapped_r ? {1'b0, search_start_r} : len_cap;

  // status to the controller
  always_comb begin
    stat.clear_last    = (clr_cnt_r == {ADDR_W{1'b1}});
    stat.mode          = mode_r;
    stat.scan_in_range = (idx_r < scan_limit);
    stat.scan_wrapped  = wrapped_r;
    stat.scan_hit      = (ram_rdata == FREE_LINK);
    stat.walk_live     = (cur_r != '0) && (cur_r < VAL_W'(TABLE_ENTRIES));
    stat.out_busy      = out_valid_r && !out_ready;
  end

  // table port steering; request writes to cluster zero are dropped
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = clr_cnt_r;
    ram_wdata = FREE_LINK;
    ram_raddr = idx_r[ADDR_W-1:0];
    unique case (cmd.op)
      DP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = (clr_cnt_r == ROOT_CLUSTER) ? END_OF_CHAIN : FREE_LINK;
      end
      DP_SCAN_RD: ram_raddr = idx_r[ADDR_W-1:0];
      DP_LINK: begin
        ram_we    = (clst_r != NO_CLUSTER);
        ram_waddr = clst_r;
        ram_wdata = VAL_W'(idx_r);
      end
      DP_MARK: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[ADDR_W-1:0];
        ram_wdata = END_OF_CHAIN;
      end
      DP_WALK_RD: ram_raddr = cur_r[ADDR_W-1:0];
      DP_WALK_EV: begin
        ram_we    = 1'b1;
        ram_waddr = cur_r[ADDR_W-1:0];
        ram_wdata = FREE_LINK;
      end
      DP_END_PREV: begin
        ram_we    = (prev_r != NO_CLUSTER);
        ram_waddr = prev_r;
        ram_wdata = END_OF_CHAIN;
      end
      DP_PUT: begin
        ram_we    = (clst_r != NO_CLUSTER);
        ram_waddr = clst_r;
        ram_wdata = val_r;
      end
      DP_GET_RD: ram_raddr = clst_r;
      default: ;
    endcase
  end

  // register updates
  always_comb begin
    clr_cnt_nxt      = clr_cnt_r;
    cfg_len_nxt      = cfg_len_r;
    search_start_nxt = search_start_r;
    out_valid_nxt    = out_valid_r;
    mode_nxt         = mode_r;
    clst_nxt         = clst_r;
    prev_nxt         = prev_r;
    val_nxt          = val_r;
    idx_nxt          = idx_r;
    wrapped_nxt      = wrapped_r;
    cur_nxt          = cur_r;
    res_nxt          = res_r;
    fail_nxt         = fail_r;
    out_res_nxt      = out_res_r;
    out_stat_nxt     = out_stat_r;

    if (cfg_valid) begin
      cfg_len_nxt = cfg_entries_in_use;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (cmd.op)
      DP_CLEAR: clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      DP_CAPTURE: begin
        mode_nxt    = mode_t'(in_mode);
        clst_nxt    = in_cluster;
        prev_nxt    = in_prev_cluster;
        val_nxt     = in_entry_value;
        idx_nxt     = {1'b0, search_start_r};
        wrapped_nxt = 1'b0;
        cur_nxt     = VAL_W'(in_cluster);
        res_nxt     = '0;
        fail_nxt    = 1'b0;
      end
      DP_SCAN_EV: begin
        if (ram_rdata == FREE_LINK) begin
          search_start_nxt = idx_r[ADDR_W-1:0];
          res_nxt          = VAL_W'(idx_r);
        end else begin
          idx_nxt = idx_r + LEN_W'(1);
        end
      end
      DP_SCAN_WRAP: begin
        idx_nxt     = FIRST_DATA_CLUSTER;
        wrapped_nxt = 1'b1;
      end
      DP_SCAN_FAIL: fail_nxt = 1'b1;
      DP_WALK_EV:   cur_nxt  = (ram_rdata == END_OF_CHAIN) ? '0 : ram_rdata;
      DP_GET_EV:    res_nxt  = ram_rdata;
      DP_FINISH: begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = res_r;
        out_stat_nxt  = fail_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r      <= '0;
      cfg_len_r      <= LEN_W'(TABLE_ENTRIES);
      search_start_r <= ROOT_CLUSTER;
      out_valid_r    <= 1'b0;
    end else begin
      clr_cnt_r      <= clr_cnt_nxt;
      cfg_len_r      <= cfg_len_nxt;
      search_start_r <= search_start_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    clst_r     <= clst_nxt;
    prev_r     <= prev_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    wrapped_r  <= wrapped_nxt;
    cur_r      <= cur_nxt;
    res_r      <= res_nxt;
    fail_r     <= fail_nxt;
    out_res_r  <= out_res_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_value = out_res_r;
  assign out_status       = out_stat_r;

endmodule

// File: design/fcc_chk.sv
`timescale 1ns / 1ps

module fcc_chk import fcc_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [VAL_W-1:0] out_result_value,
  input logic             out_status
);

  // words accepted but not yet delivered
  logic [1:0] pending_r, pending_nxt;

  always_comb begin
    pending_nxt = pending_r;
    if ((in_valid && in_ready) && !(out_valid && out_ready)) begin
      pending_nxt = pending_r + 2'd1;
    end else if (!(in_valid && in_ready) && (out_valid && out_ready)) begin
      pending_nxt = pending_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result word holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_value) && $stable(out_status))
    else $error("result word changed while stalled");

  // no result word without a request behind it
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("result word with no pending request");

  // at most one request in work and one result waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many requests in flight");

  // a failed allocation reports cluster zero
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_result_value == '0)
    else $error("failed allocation with nonzero cluster");

endmodule

bind fat_cluster_chain_manager fcc_chk u_fcc_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_result_value (out_rsp.result_value),
  .out_status       (out_rsp.status)
);

// File: bench/fat_cluster_chain_manager_checker.sv
`timescale 1ns / 1ps

// watches the request, result and configuration channels, keeps its own copy
// of the link table and the next-fit pointer, and checks every result word
module fat_cluster_chain_manager_checker import fcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  fcc_req_if   req,
  fcc_rsp_if   rsp,
  fcc_cfg_if   cfg,
  output int   failures,
  output int   pending
);

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             status;
  } reply_t;

  // shadow state of the block
  logic [VAL_W-1:0]  links [TABLE_ENTRIES];
  logic [ADDR_W-1:0] next_fit;
  logic [LEN_W-1:0]  in_use_len;

  reply_t predicted_replies [$];
  int     words_seen;

  // out-of-table clusters read as free
  function automatic logic [VAL_W-1:0] link_at(int unsigned c);
    if (c == 0 || c >= TABLE_ENTRIES) return FREE_LINK;
    return links[c];
  endfunction

  // writes to cluster zero or beyond the table are dropped
  function automatic void set_link(int unsigned c, logic [VAL_W-1:0] v);
    if (c == 0 || c >= TABLE_ENTRIES) return;
    links[c] = v;
  endfunction

  // next-fit scan: pointer up to the in-use length, then 2 up to the pointer
  function automatic int unsigned free_search();
    int unsigned lim;
    int unsigned i;
    lim = in_use_len;
    if (lim > TABLE_ENTRIES) lim = TABLE_ENTRIES;
    for (i = next_fit; i < lim; i++)
      if (i != 0 && link_at(i) == FREE_LINK) return i;
    for (i = FIRST_DATA_CLUSTER; i < next_fit && i < TABLE_ENTRIES; i++)
      if (link_at(i) == FREE_LINK) return i;
    return 0;
  endfunction

  // applies one request to the shadow table and returns the result word
  function automatic reply_t serve_request(mode_t m, logic [ADDR_W-1:0] c,
                                           logic [ADDR_W-1:0] p,
                                           logic [VAL_W-1:0] v);
    reply_t      r;
    int unsigned f;
    int unsigned cur;
    int unsigned nxt;
    int unsigned hops;
    r = '0;
    case (m)
      MODE_ALLOC: begin
        f = free_search();
        if (f == 0) begin
          r.status = 1'b1;
        end else begin
          next_fit = ADDR_W'(f);
          if (c != NO_CLUSTER) set_link(c, VAL_W'(f));
          set_link(f, END_OF_CHAIN);
          r.value = VAL_W'(f);
        end
      end
      MODE_REMOVE: begin
        // free as we go, so a cyclic chain runs into a free entry
        cur = c;
        hops = 0;
        while (cur != 0 && link_at(cur) != END_OF_CHAIN && hops <= TABLE_ENTRIES) begin
          nxt = link_at(cur);
          set_link(cur, FREE_LINK);
          cur = nxt;
          hops++;
        end
        if (cur != 0) set_link(cur, FREE_LINK);
        if (p != NO_CLUSTER) set_link(p, END_OF_CHAIN);
      end
      MODE_WRITE: begin
        set_link(c, v);
      end
      default: begin
        r.value = link_at(c);
      end
    endcase
    return r;
  endfunction

  // sample all channels at the rising edge
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) links[i] = FREE_LINK;
      links[ROOT_CLUSTER] = END_OF_CHAIN;
      next_fit   = ROOT_CLUSTER;
      in_use_len = LEN_W'(TABLE_ENTRIES);
      predicted_replies.delete();
      failures   = 0;
      words_seen = 0;
    end else begin
      if (cfg.valid && cfg.ready) in_use_len = cfg.entries_in_use;

      // result word against the oldest prediction
      if (rsp.valid && rsp.ready) begin
        words_seen++;
        if (predicted_replies.size() == 0) begin
          if (failures < 10)
            $display("unexpected result word %0d: value %h status %b",
                     words_seen, rsp.result_value, rsp.status);
          failures++;
        end else begin
          want = predicted_replies.pop_front();
          if (rsp.result_value !== want.value || rsp.status !== want.status) begin
            if (failures < 10)
              $display("result word %0d: expected value %h status %b, got value %h status %b",
                       words_seen, want.value, want.status, rsp.result_value, rsp.status);
            failures++;
          end
        end
      end

      // request word accepted
      if (req.valid && req.ready)
        predicted_replies.push_back(serve_request(mode_t'(req.mode), req.cluster,
                                                  req.prev_cluster, req.entry_value));
    end
    pending = predicted_replies.size();
  end

endmodule

// File: bench/fat_cluster_chain_manager_test.sv
`timescale 1ns / 1ps

module fat_cluster_chain_manager_test;
  import fcc_pkg::*;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 119;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic calm  = 1'b0;

  fcc_req_if req_ch ();
  fcc_rsp_if rsp_ch ();
  fcc_cfg_if cfg_ch ();

  int failures;
  int pending;
  int sent [4];
  int cfg_writes;
  int random_count;
  logic [LEN_W-1:0] cur_len;

  fat_cluster_chain_manager u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  fat_cluster_chain_manager_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (req_ch),
    .rsp      (rsp_ch),
    .cfg      (cfg_ch),
    .failures (failures),
    .pending  (pending)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // result side back-pressure
  always @(negedge clk) begin
    rsp_ch.ready <= calm || ($urandom_range(99) >= 8);
  end

  // one request word, with an occasional idle gap before it
  task automatic send_req(mode_t m, logic [ADDR_W-1:0] c, logic [ADDR_W-1:0] p,
                          logic [VAL_W-1:0] v);
    while (!calm && $urandom_range(99) < 8) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= m;
    req_ch.cluster      <= c;
    req_ch.prev_cluster <= p;
    req_ch.entry_value  <= v;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent[int'(m)]++;
    @(negedge clk);
  endtask

  // drop valid and wait until every result word is back
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_len(logic [LEN_W-1:0] n);
    cfg_ch.valid          <= 1'b1;
    cfg_ch.entries_in_use <= n;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_len = n;
    cfg_writes++;
  endtask

  // mostly clusters near the in-use region so chains build up and get walked
  task automatic random_req();
    int unsigned      hi;
    int unsigned      pick;
    mode_t            m;
    logic [ADDR_W-1:0] c;
    logic [ADDR_W-1:0] p;
    logic [VAL_W-1:0]  v;
    hi = (cur_len > 400) ? 400 : cur_len + 1;
    c = ($urandom_range(9) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(hi, 0));
    p = ($urandom_range(9) == 0) ? ADDR_W'($urandom) : ADDR_W'($urandom_range(hi, 0));
    v = VAL_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 40) begin
      m = MODE_ALLOC;
      if ($urandom_range(9) < 4) c = NO_CLUSTER;
    end else if (pick < 60) begin
      m = MODE_REMOVE;
      if ($urandom_range(1) == 0) p = NO_CLUSTER;
    end else if (pick < 75) begin
      m = MODE_WRITE;
      pick = $urandom_range(9);
      if (pick < 3) v = VAL_W'($urandom_range(hi, 2));
      else if (pick < 5) v = END_OF_CHAIN;
      else if (pick < 7) v = FREE_LINK;
    end else begin
      m = MODE_READ;
    end
    send_req(m, c, p, v);
  endtask

  // stimulus
  initial begin
    int unsigned phase_len [PHASES];
    req_ch.valid        = 1'b0;
    req_ch.mode         = MODE_READ;
    req_ch.cluster      = '0;
    req_ch.prev_cluster = '0;
    req_ch.entry_value  = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.entries_in_use = LEN_W'(TABLE_ENTRIES);
    rsp_ch.ready = 1'b0;
    cur_len = LEN_W'(TABLE_ENTRIES);
    phase_len = '{4096, 64, 3, 4095, 0, 4096, 17, 4096};
    phase_len[4] = $urandom_range(300, 8);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_len(LEN_W'(4096));

    // root entry, cluster zero ignored on write and read as zero
    send_req(MODE_READ,   12'd1, 12'd0, 16'h0000);
    send_req(MODE_READ,   12'd0, 12'd0, 16'h0000);
    send_req(MODE_WRITE,  12'd0, 12'd0, 16'h1234);
    send_req(MODE_READ,   12'd0, 12'd0, 16'h0000);
    // build a three-cluster chain and remove it, root marked as new end
    send_req(MODE_ALLOC,  12'd0, 12'd0, 16'h0000);
    send_req(MODE_ALLOC,  12'd2, 12'd0, 16'h0000);
    send_req(MODE_ALLOC,  12'd3, 12'd0, 16'h0000);
    send_req(MODE_REMOVE, 12'd2, 12'd1, 16'h0000);
    // top cluster and all-ones value
    send_req(MODE_WRITE,  12'd4095, 12'd0, 16'hFFFF);
    send_req(MODE_READ,   12'd4095, 12'd0, 16'h0000);
    // cyclic chain
    send_req(MODE_WRITE,  12'd5, 12'd0, 16'h0006);
    send_req(MODE_WRITE,  12'd6, 12'd0, 16'h0005);
    send_req(MODE_REMOVE, 12'd5, 12'd0, 16'h0000);
    // link pointing beyond the table
    send_req(MODE_WRITE,  12'd7, 12'd0, 16'h8000);
    send_req(MODE_REMOVE, 12'd7, 12'd0, 16'h0000);
    // chain walk that reaches zero
    send_req(MODE_WRITE,  12'd8, 12'd0, 16'h0000);
    send_req(MODE_REMOVE, 12'd8, 12'd0, 16'h0000);
    // free tail that is itself the found cluster, then a different free tail
    send_req(MODE_ALLOC,  12'd4, 12'd0, 16'h0000);
    send_req(MODE_ALLOC,  12'd100, 12'd0, 16'h0000);
    // remove of no chain, only the new end marked
    send_req(MODE_REMOVE, 12'd0, 12'd4095, 16'h0000);
    send_req(MODE_READ,   12'd4095, 12'd0, 16'h0000);
    settle();

    // length below the pointer: wrapped pass only, then no free entry
    write_len(LEN_W'(3));
    send_req(MODE_ALLOC,  12'd0, 12'd0, 16'h0000);
    send_req(MODE_ALLOC,  12'd0, 12'd0, 16'h0000);
    send_req(MODE_READ,   12'd2, 12'd0, 16'h0000);
    settle();

    // random phases over several table lengths
    for (int ph = 0; ph < PHASES; ph++) begin
      write_len(LEN_W'(phase_len[ph]));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        calm = (random_count >= 300 && random_count < 450);
        random_req();
        random_count++;
      end
      calm = 1'b0;
      settle();
    end

    repeat (50) @(negedge clk);
    $display("covered %0d requests: %0d allocate, %0d remove, %0d write, %0d read",
             sent[0] + sent[1] + sent[2] + sent[3], sent[0], sent[1], sent[2], sent[3]);
    $display("over %0d table length settings between 3 and 4096", cfg_writes);
    if (failures == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  // run time limit
  initial begin
    #600ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
